>>> rtl/core/intel_hex_record_writer_core_assert.svh
// Assertion macros of the record writer core, used by ihrw_datapath.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef INTEL_HEX_RECORD_WRITER_CORE_ASSERT_SVH
`define INTEL_HEX_RECORD_WRITER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHRW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IHRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ihrw_pkg.sv
// Types, codes and helper functions of the Intel HEX record writer core.
// Used by ihrw_ctrl, ihrw_datapath and the top level; depends on nothing.
package ihrw_pkg;

   localparam int FUNC_W      = 2;
   localparam int ADDR_W      = 23;
   localparam int DATA_W      = 16;
   localparam int CHAR_W      = 8;
   localparam int SEG_W       = 8;
   localparam int LADDR_W     = 24;
   localparam int REQ_TDATA_W = 40;
   localparam int SEG_REC_LEN = 2;

   localparam logic [FUNC_W-1:0] FUNC_WORD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd2;

   localparam logic [7:0] RTYPE_DATA    = 8'h00;
   localparam logic [7:0] RTYPE_EOF     = 8'h01;
   localparam logic [7:0] RTYPE_EXT_SEG = 8'h02;
   localparam logic [7:0] RTYPE_EXT_LIN = 8'h04;

   localparam logic [CHAR_W-1:0] ASCII_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] ASCII_LF    = 8'h0A;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN,
      ST_COLON,
      ST_HEAD,
      ST_BODY,
      ST_CSUM,
      ST_CR,
      ST_LF,
      ST_COMMIT
   } state_type;

   typedef enum logic [1:0] {
      REC_DATA,
      REC_SEG,
      REC_EOF
   } rec_type;

   typedef enum logic [2:0] {
      F_COUNT,
      F_OFFHI,
      F_OFFLO,
      F_TYPE,
      F_PAYLOAD,
      F_CSUM
   } field_type;

   typedef enum logic [1:0] {
      CH_COLON,
      CH_HEX,
      CH_CR,
      CH_LF
   } char_sel_type;

   typedef struct packed {
      logic         latch;
      logic         emit;
      logic         last;
      char_sel_type sel;
      field_type    field;
      rec_type      rec;
      logic         nib_hi;
      logic         clear_fill;
      logic         commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic flush_req;
      logic seg_req;
      logic eof_req;
      logic pay_none;
      logic pay_last;
   } status_type;

   function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
      logic [CHAR_W-1:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         return 8'h30 + wide;
      end else begin
         return 8'h37 + wide;
      end
   endfunction

endpackage

>>> rtl/core/ihrw_ctrl.sv
// Sequencer of the record writer: plans the records of one item and walks
// their characters. Depends on ihrw_pkg; drives ihrw_datapath by commands.
module ihrw_ctrl #(
   parameter int  LINE_BYTES = 16,
   localparam int IW = $clog2(LINE_BYTES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ihrw_pkg::status_type  status,
   output ihrw_pkg::cmd_type     cmd,
   output logic [IW-1:0]         pay_idx
);

   ihrw_pkg::state_type state_ff, state_in;
   ihrw_pkg::rec_type   rec_ff, rec_in;
   ihrw_pkg::field_type head_ff, head_in;
   logic                seg_pend_ff, seg_pend_in;
   logic                eof_pend_ff, eof_pend_in;
   logic                nib_ff, nib_in;
   logic [IW-1:0]       pay_ff, pay_in;

   assign pay_idx = pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ihrw_pkg::ST_IDLE;
         rec_ff      <= ihrw_pkg::REC_DATA;
         head_ff     <= ihrw_pkg::F_COUNT;
         seg_pend_ff <= 1'b0;
         eof_pend_ff <= 1'b0;
         nib_ff      <= 1'b0;
         pay_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         rec_ff      <= rec_in;
         head_ff     <= head_in;
         seg_pend_ff <= seg_pend_in;
         eof_pend_ff <= eof_pend_in;
         nib_ff      <= nib_in;
         pay_ff      <= pay_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rec_in         = rec_ff;
      head_in        = head_ff;
      seg_pend_in    = seg_pend_ff;
      eof_pend_in    = eof_pend_ff;
      nib_in         = nib_ff;
      pay_in         = pay_ff;
      req_tready     = 1'b0;
      cmd.latch      = 1'b0;
      cmd.emit       = 1'b0;
      cmd.last       = 1'b0;
      cmd.sel        = ihrw_pkg::CH_HEX;
      cmd.field      = head_ff;
      cmd.rec        = rec_ff;
      cmd.nib_hi     = !nib_ff;
      cmd.clear_fill = 1'b0;
      cmd.commit     = 1'b0;

      unique case (state_ff)
         ihrw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ihrw_pkg::ST_PLAN;
            end
         end
         ihrw_pkg::ST_PLAN: begin
            seg_pend_in = status.seg_req;
            eof_pend_in = status.eof_req;
            if (status.flush_req) begin
               rec_in   = ihrw_pkg::REC_DATA;
               state_in = ihrw_pkg::ST_COLON;
            end else if (status.seg_req) begin
               rec_in   = ihrw_pkg::REC_SEG;
               state_in = ihrw_pkg::ST_COLON;
            end else if (status.eof_req) begin
               rec_in   = ihrw_pkg::REC_EOF;
               state_in = ihrw_pkg::ST_COLON;
            end else begin
               state_in = ihrw_pkg::ST_COMMIT;
            end
         end
         ihrw_pkg::ST_COLON: begin
            cmd.sel = ihrw_pkg::CH_COLON;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               head_in  = ihrw_pkg::F_COUNT;
               nib_in   = 1'b0;
               state_in = ihrw_pkg::ST_HEAD;
            end
         end
         ihrw_pkg::ST_HEAD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               nib_in   = !nib_ff;
               if (nib_ff) begin
                  unique case (head_ff)
                     ihrw_pkg::F_COUNT: head_in = ihrw_pkg::F_OFFHI;
                     ihrw_pkg::F_OFFHI: head_in = ihrw_pkg::F_OFFLO;
                     ihrw_pkg::F_OFFLO: head_in = ihrw_pkg::F_TYPE;
                     default: begin
                        pay_in = '0;
                        if (status.pay_none) begin
                           state_in = ihrw_pkg::ST_CSUM;
                        end else begin
                           state_in = ihrw_pkg::ST_BODY;
                        end
                     end
                  endcase
               end
            end
         end
         ihrw_pkg::ST_BODY: begin
            cmd.field = ihrw_pkg::F_PAYLOAD;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               nib_in   = !nib_ff;
               if (nib_ff) begin
                  if (status.pay_last) begin
                     state_in = ihrw_pkg::ST_CSUM;
                  end else begin
                     pay_in = pay_ff + IW'(1);
                  end
               end
            end
         end
         ihrw_pkg::ST_CSUM: begin
            cmd.field = ihrw_pkg::F_CSUM;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               nib_in   = !nib_ff;
               if (nib_ff) begin
                  state_in = ihrw_pkg::ST_CR;
               end
            end
         end
         ihrw_pkg::ST_CR: begin
            cmd.sel = ihrw_pkg::CH_CR;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ihrw_pkg::ST_LF;
            end
         end
         ihrw_pkg::ST_LF: begin
            cmd.sel = ihrw_pkg::CH_LF;
            // Only a data record can be followed by another record of the same item.
            cmd.last = !(rec_ff == ihrw_pkg::REC_DATA && (seg_pend_ff || eof_pend_ff));
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ihrw_pkg::ST_COMMIT;
               if (rec_ff == ihrw_pkg::REC_DATA) begin
                  cmd.clear_fill = 1'b1;
                  if (seg_pend_ff) begin
                     rec_in   = ihrw_pkg::REC_SEG;
                     state_in = ihrw_pkg::ST_COLON;
                  end else if (eof_pend_ff) begin
                     rec_in   = ihrw_pkg::REC_EOF;
                     state_in = ihrw_pkg::ST_COLON;
                  end
               end
            end
         end
         ihrw_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ihrw_pkg::ST_IDLE;
         end
         default: begin
            state_in = ihrw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/ihrw_datapath.sv
// Datapath of the record writer: request latch, line buffer, segment state,
// checksum, character generation and the result register.
// Depends on ihrw_pkg and intel_hex_record_writer_core_assert.svh.
`include "intel_hex_record_writer_core_assert.svh"

module ihrw_datapath #(
   parameter int  LINE_BYTES = 16,
   localparam int IW = $clog2(LINE_BYTES),
   localparam int FW = $clog2(LINE_BYTES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ihrw_pkg::cmd_type                 cmd,
   input  logic [IW-1:0]                     pay_idx,
   output ihrw_pkg::status_type              status,
   input  logic [ihrw_pkg::FUNC_W-1:0]       req_func,
   input  logic [ihrw_pkg::ADDR_W-1:0]       req_address,
   input  logic [ihrw_pkg::DATA_W-1:0]       req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ihrw_pkg::CHAR_W-1:0]       rsp_char,
   output logic                              rsp_last
);

   logic [ihrw_pkg::FUNC_W-1:0]  func_ff;
   logic [ihrw_pkg::ADDR_W-1:0]  addr_ff;
   logic [ihrw_pkg::DATA_W-1:0]  data_ff;

   logic                         seg_known_ff, seg_known_in;
   logic [ihrw_pkg::SEG_W-1:0]   cur_seg_ff, cur_seg_in;
   logic [ihrw_pkg::LADDR_W-1:0] line_start_ff, line_start_in;
   logic [FW-1:0]                fill_ff, fill_in;
   logic [7:0]                   line_ff [LINE_BYTES];
   logic [7:0]                   sum_ff, sum_in;
   logic                         out_valid_ff, out_valid_in;
   logic [ihrw_pkg::CHAR_W-1:0]  out_char_ff, out_char_in;
   logic                         out_last_ff, out_last_in;

   logic [ihrw_pkg::LADDR_W-1:0] baddr;
   logic [ihrw_pkg::SEG_W-1:0]   req_seg;
   logic                         seg_ext;
   logic [15:0]                  seg_val;
   logic                         is_word;
   logic                         seg_change;
   logic [ihrw_pkg::LADDR_W:0]   eff_addr;
   logic [ihrw_pkg::LADDR_W:0]   line_end;
   logic [FW:0]                  fill_need;
   logic                         breaks;
   logic [FW-1:0]                pay_len;
   logic [FW-1:0]                pay_next;
   logic [FW-1:0]                wr_hi;
   logic [7:0]                   cur_byte;
   logic [3:0]                   nibble;
   logic [ihrw_pkg::CHAR_W-1:0]  char_val;
   logic                         out_free;

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff <= req_func;
         addr_ff <= req_address;
         data_ff <= req_data;
      end
   end

   assign is_word  = (func_ff == ihrw_pkg::FUNC_WORD);
   assign baddr    = {addr_ff, 1'b0};
   assign req_seg  = baddr[ihrw_pkg::LADDR_W-1 -: ihrw_pkg::SEG_W];
   // Segments from 16 up need an extended linear address record.
   assign seg_ext  = |req_seg[7:4];
   assign seg_val  = seg_ext ? {8'h00, req_seg} : {req_seg[3:0], 12'h000};
   assign seg_change = is_word && (!seg_known_ff || req_seg != cur_seg_ff);

   assign eff_addr  = is_word ? {1'b0, baddr} : {2'b00, addr_ff};
   assign line_end  = {1'b0, line_start_ff} + (ihrw_pkg::LADDR_W + 1)'(fill_ff);
   assign fill_need = {1'b0, fill_ff} + (is_word ? (FW + 1)'(2) : (FW + 1)'(1));
   assign breaks    = (fill_need > (FW + 1)'(LINE_BYTES)) ||
                      (fill_ff != '0 && eff_addr != line_end);

   always_comb begin
      unique case (cmd.rec)
         ihrw_pkg::REC_DATA: pay_len = fill_ff;
         ihrw_pkg::REC_SEG:  pay_len = FW'(ihrw_pkg::SEG_REC_LEN);
         default:            pay_len = '0;
      endcase
   end

   assign pay_next = FW'(pay_idx) + FW'(1);

   always_comb begin
      status.out_free = out_free;
      status.seg_req  = seg_change;
      status.eof_req  = (func_ff == ihrw_pkg::FUNC_CLOSE);
      status.pay_none = (pay_len == '0);
      status.pay_last = (pay_next == pay_len);
      unique case (func_ff)
         ihrw_pkg::FUNC_WORD:  status.flush_req = (seg_change && fill_ff != '0) || breaks;
         ihrw_pkg::FUNC_BYTE:  status.flush_req = breaks;
         ihrw_pkg::FUNC_CLOSE: status.flush_req = (fill_ff != '0);
         default:              status.flush_req = 1'b0;
      endcase
   end

   // Byte of the record field being printed.
   always_comb begin
      unique case (cmd.field)
         ihrw_pkg::F_COUNT: begin
            unique case (cmd.rec)
               ihrw_pkg::REC_DATA: cur_byte = 8'(fill_ff);
               ihrw_pkg::REC_SEG:  cur_byte = 8'(ihrw_pkg::SEG_REC_LEN);
               default:            cur_byte = 8'h00;
            endcase
         end
         ihrw_pkg::F_OFFHI: begin
            cur_byte = (cmd.rec == ihrw_pkg::REC_DATA) ? line_start_ff[15:8] : 8'h00;
         end
         ihrw_pkg::F_OFFLO: begin
            cur_byte = (cmd.rec == ihrw_pkg::REC_DATA) ? line_start_ff[7:0] : 8'h00;
         end
         ihrw_pkg::F_TYPE: begin
            unique case (cmd.rec)
               ihrw_pkg::REC_DATA: cur_byte = ihrw_pkg::RTYPE_DATA;
               ihrw_pkg::REC_SEG:
                  cur_byte = seg_ext ? ihrw_pkg::RTYPE_EXT_LIN : ihrw_pkg::RTYPE_EXT_SEG;
               default:            cur_byte = ihrw_pkg::RTYPE_EOF;
            endcase
         end
         ihrw_pkg::F_PAYLOAD: begin
            if (cmd.rec == ihrw_pkg::REC_DATA) begin
               cur_byte = line_ff[pay_idx];
            end else begin
               cur_byte = (pay_idx == '0) ? seg_val[15:8] : seg_val[7:0];
            end
         end
         default: begin
            cur_byte = 8'h00 - sum_ff;
         end
      endcase
   end

   assign nibble = cmd.nib_hi ? cur_byte[7:4] : cur_byte[3:0];

   always_comb begin
      unique case (cmd.sel)
         ihrw_pkg::CH_COLON: char_val = ihrw_pkg::ASCII_COLON;
         ihrw_pkg::CH_HEX:   char_val = ihrw_pkg::hex_ascii(nibble);
         ihrw_pkg::CH_CR:    char_val = ihrw_pkg::ASCII_CR;
         default:            char_val = ihrw_pkg::ASCII_LF;
      endcase
   end

   // Running checksum; a byte counts once its low digit goes out.
   always_comb begin
      sum_in = sum_ff;
      if (cmd.emit) begin
         if (cmd.sel == ihrw_pkg::CH_COLON) begin
            sum_in = 8'h00;
         end else if (cmd.sel == ihrw_pkg::CH_HEX && !cmd.nib_hi &&
                      cmd.field != ihrw_pkg::F_CSUM) begin
            sum_in = sum_ff + cur_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // Line state and segment state, updated at commit; the fill also clears as a data record ends.
   always_comb begin
      seg_known_in  = seg_known_ff;
      cur_seg_in    = cur_seg_ff;
      line_start_in = line_start_ff;
      fill_in       = fill_ff;
      if (cmd.clear_fill) begin
         fill_in = '0;
      end
      if (cmd.commit) begin
         unique case (func_ff)
            ihrw_pkg::FUNC_WORD: begin
               if (seg_change) begin
                  seg_known_in = 1'b1;
                  cur_seg_in   = req_seg;
               end
               if (fill_ff == '0) begin
                  line_start_in = baddr;
               end
               fill_in = fill_ff + FW'(2);
            end
            ihrw_pkg::FUNC_BYTE: begin
               if (fill_ff == '0) begin
                  line_start_in = {1'b0, addr_ff};
               end
               fill_in = fill_ff + FW'(1);
            end
            ihrw_pkg::FUNC_CLOSE: begin
               seg_known_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_known_ff  <= 1'b0;
         cur_seg_ff    <= '0;
         line_start_ff <= '0;
         fill_ff       <= '0;
      end else begin
         seg_known_ff  <= seg_known_in;
         cur_seg_ff    <= cur_seg_in;
         line_start_ff <= line_start_in;
         fill_ff       <= fill_in;
      end
   end

   assign wr_hi = fill_ff + FW'(1);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (func_ff == ihrw_pkg::FUNC_WORD) begin
            line_ff[fill_ff[IW-1:0]] <= data_ff[7:0];
            line_ff[wr_hi[IW-1:0]]   <= data_ff[15:8];
         end else if (func_ff == ihrw_pkg::FUNC_BYTE) begin
            line_ff[fill_ff[IW-1:0]] <= data_ff[7:0];
         end
      end
   end

   // Result register.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_char_in  = char_val;
         out_last_in  = cmd.last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_char  = out_char_ff;
   assign rsp_last  = out_last_ff;

   `IHRW_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(LINE_BYTES),
      "line buffer fill count exceeds the line length")
   `IHRW_ASSERT_NOW(a_emit_when_free, clock, reset, cmd.emit, out_free,
      "character issued while the result register is still occupied")
   `IHRW_ASSERT_NOW(a_payload_filled, clock, reset,
      cmd.emit && cmd.field == ihrw_pkg::F_PAYLOAD && cmd.rec == ihrw_pkg::REC_DATA,
      FW'(pay_idx) < fill_ff, "data record reads an unfilled line entry")
   `IHRW_ASSERT_NEXT(a_word_buffered, clock, reset,
      cmd.commit && func_ff == ihrw_pkg::FUNC_WORD, fill_ff >= FW'(2),
      "word write did not leave both bytes in the line buffer")

endmodule

>>> rtl/core/intel_hex_record_writer_core.sv
// Channel  Dir  Transfer content
// req      in   tuser: func; tdata: address, data
// rsp      out  tdata: hex_char; tlast: last character of the item
//
// An item with no record is accepted, planned and committed; otherwise its
// records' characters are issued between the plan and the commit steps.
// Within a record, characters leave at one per cycle while rsp_tready is high,
// set by the single result register.
// Synchronous reset empties the line buffer, forgets the segment and
// discards any character waiting in the result register.
// rsp_tready low stalls the character sequencer; the next item is taken as
// soon as the previous one is committed, even while its last character waits.
module intel_hex_record_writer_core #(
   parameter int LINE_BYTES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [22:0] address, [38:23] data, [39] zero
   input  logic [ihrw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] func
   input  logic [ihrw_pkg::FUNC_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] hex_char
   output logic [ihrw_pkg::CHAR_W-1:0]       rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int IW = $clog2(LINE_BYTES);

   ihrw_pkg::cmd_type    cmd;
   ihrw_pkg::status_type status;
   logic [IW-1:0]        pay_idx;

   ihrw_ctrl #(
      .LINE_BYTES (LINE_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .pay_idx    (pay_idx)
   );

   ihrw_datapath #(
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .pay_idx     (pay_idx),
      .status      (status),
      .req_func    (req_tuser),
      .req_address (req_tdata[ihrw_pkg::ADDR_W-1:0]),
      .req_data    (req_tdata[ihrw_pkg::ADDR_W +: ihrw_pkg::DATA_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_char    (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

endmodule

>>> sim/intel_hex_record_writer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for intel_hex_record_writer_core: predicts the Intel HEX
// text of each accepted write and compares it character by character with the output.
// Depends on ihrw_pkg and the core RTL only.
module intel_hex_record_writer_core_tb;

   localparam int LINE_CAP       = 16;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int SETTLE_CYCLES  = 80;
   localparam int ITEMS_PER_PASS = 120;

   localparam logic [ihrw_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [ihrw_pkg::FUNC_W-1:0] func;
      logic [ihrw_pkg::ADDR_W-1:0] address;
      logic [ihrw_pkg::DATA_W-1:0] data;
   } write_item_type;

   typedef struct {
      logic [ihrw_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } hex_char_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ihrw_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [ihrw_pkg::FUNC_W-1:0]      req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ihrw_pkg::CHAR_W-1:0]      rsp_tdata;
   logic                             rsp_tlast;

   write_item_type pending_writes[$];
   hex_char_type   expected_text[$];
   logic [7:0]     item_text[$];
   logic           req_taken = 1'b0;
   int             mismatch_total = 0;
   int             cycle_count = 0;
   int unsigned    tx_idle_pct = 0;
   int unsigned    rx_idle_pct = 0;
   logic [23:0]    next_byte = '0;

   // Predictor state: segment tracking and the open line.
   logic          seg_valid = 1'b0;
   logic [7:0]    seg_now = '0;
   int unsigned   line_base = 0;
   int unsigned   line_fill = 0;
   logic [7:0]    line_buf[LINE_CAP];

   intel_hex_record_writer_core #(
      .LINE_BYTES(LINE_CAP)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void say_char(input logic [7:0] c);
      item_text.push_back(c);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'h30 + {4'd0, n};
      end else begin
         return 8'h41 + {4'd0, n} - 8'd10;
      end
   endfunction

   function automatic void say_byte(input logic [7:0] v);
      say_char(hex_digit(v[7:4]));
      say_char(hex_digit(v[3:0]));
   endfunction

   function automatic void say_word(input logic [15:0] v);
      say_byte(v[15:8]);
      say_byte(v[7:0]);
   endfunction

   function automatic void say_line_end();
      say_char(ihrw_pkg::ASCII_CR);
      say_char(ihrw_pkg::ASCII_LF);
   endfunction

   // Only the low 16 bits of the line base go into the load offset.
   function automatic void write_data_record();
      logic [15:0] off;
      logic [7:0]  sum;
      off = line_base[15:0];
      say_char(ihrw_pkg::ASCII_COLON);
      say_byte(8'(line_fill));
      say_word(off);
      say_byte(ihrw_pkg::RTYPE_DATA);
      sum = 8'(line_fill) + off[15:8] + off[7:0];
      for (int i = 0; i < int'(line_fill); i++) begin
         say_byte(line_buf[i]);
         sum = sum + line_buf[i];
      end
      say_byte(8'd0 - sum);
      say_line_end();
      line_fill = 0;
   endfunction

   function automatic void write_segment_record(input logic [7:0] seg);
      logic [15:0] val;
      logic [7:0]  rtype;
      if (seg >= 8'd16) begin
         val = {8'd0, seg};
         rtype = ihrw_pkg::RTYPE_EXT_LIN;
      end else begin
         val = {seg[3:0], 12'd0};
         rtype = ihrw_pkg::RTYPE_EXT_SEG;
      end
      say_char(ihrw_pkg::ASCII_COLON);
      say_byte(8'(ihrw_pkg::SEG_REC_LEN));
      say_word(16'd0);
      say_byte(rtype);
      say_word(val);
      say_byte(8'd0 - (8'(ihrw_pkg::SEG_REC_LEN) + rtype + val[15:8] + val[7:0]));
      say_line_end();
   endfunction

   function automatic void write_eof_record();
      say_char(ihrw_pkg::ASCII_COLON);
      say_byte(8'd0);
      say_word(16'd0);
      say_byte(ihrw_pkg::RTYPE_EOF);
      say_byte(8'd0 - ihrw_pkg::RTYPE_EOF);
      say_line_end();
   endfunction

   // Addresses are compared at full width, so the line never wraps around.
   function automatic bit starts_new_line(input int unsigned addr, input int unsigned need);
      if (line_fill + need > LINE_CAP) begin
         return 1'b1;
      end
      return line_fill != 0 && addr != line_base + line_fill;
   endfunction

   function automatic void buffer_byte(input logic [7:0] b);
      line_buf[line_fill] = b;
      line_fill++;
   endfunction

   function automatic void encode_item(input logic [ihrw_pkg::FUNC_W-1:0] func,
                                       input logic [ihrw_pkg::ADDR_W-1:0] addr,
                                       input logic [ihrw_pkg::DATA_W-1:0] data);
      int unsigned baddr;
      logic [7:0]  seg;
      item_text.delete();
      case (func)
         ihrw_pkg::FUNC_WORD: begin
            baddr = {addr, 1'b0};
            seg = 8'(baddr >> 16);
            if (!seg_valid || seg != seg_now) begin
               if (line_fill != 0) begin
                  write_data_record();
               end
               seg_valid = 1'b1;
               seg_now = seg;
               write_segment_record(seg);
            end
            if (starts_new_line(baddr, 2)) begin
               write_data_record();
            end
            if (line_fill == 0) begin
               line_base = baddr;
            end
            buffer_byte(data[7:0]);
            buffer_byte(data[15:8]);
         end
         ihrw_pkg::FUNC_BYTE: begin
            if (starts_new_line(addr, 1)) begin
               write_data_record();
            end
            if (line_fill == 0) begin
               line_base = addr;
            end
            buffer_byte(data[7:0]);
         end
         ihrw_pkg::FUNC_CLOSE: begin
            if (line_fill != 0) begin
               write_data_record();
            end
            write_eof_record();
            seg_valid = 1'b0;
         end
         default: begin
         end
      endcase
      foreach (item_text[i]) begin
         expected_text.push_back('{ch: item_text[i], last: (i == item_text.size() - 1)});
      end
   endfunction

   task automatic queue_write(input logic [ihrw_pkg::FUNC_W-1:0] func,
                              input logic [ihrw_pkg::ADDR_W-1:0] addr,
                              input logic [ihrw_pkg::DATA_W-1:0] data);
      pending_writes.push_back('{func: func, address: addr, data: data});
   endtask

   // Mostly runs of contiguous words or bytes, broken up by jumps, closes and noise.
   task automatic queue_random_writes(input int count);
      int                          made;
      int                          run;
      int unsigned                 pick;
      logic [ihrw_pkg::ADDR_W-1:0] addr;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            run = $urandom_range(12, 1);
            repeat (run) begin
               addr = next_byte[23:1];
               queue_write(ihrw_pkg::FUNC_WORD, addr, 16'($urandom_range(16'hFFFF)));
               next_byte = {addr, 1'b0} + 24'd2;
               made++;
            end
         end else if (pick < 65) begin
            run = $urandom_range(20, 1);
            repeat (run) begin
               addr = next_byte[ihrw_pkg::ADDR_W-1:0];
               queue_write(ihrw_pkg::FUNC_BYTE, addr, 16'($urandom_range(16'hFFFF)));
               next_byte = {1'b0, addr} + 24'd1;
               made++;
            end
         end else if (pick < 75) begin
            next_byte = 24'($urandom_range(24'hFFFFFF));
         end else if (pick < 83) begin
            // Land just below a 64K boundary so the next run can cross a segment.
            next_byte = {8'($urandom_range(255)), 16'($urandom_range(16'hFFFF, 16'hFFE0))};
         end else if (pick < 92) begin
            queue_write(ihrw_pkg::FUNC_CLOSE, 23'($urandom_range(23'h7FFFFF)),
                        16'($urandom_range(16'hFFFF)));
            made++;
         end else begin
            queue_write(FUNC_UNUSED, 23'($urandom_range(23'h7FFFFF)),
                        16'($urandom_range(16'hFFFF)));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_writes.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(negedge clock) begin : drive_side
      write_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         if (!req_tvalid || req_taken) begin
            if (pending_writes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               item = pending_writes.pop_front();
               req_tuser <= item.func;
               req_tdata <= {1'b0, item.data, item.address};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_side
      hex_char_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            encode_item(req_tuser, req_tdata[ihrw_pkg::ADDR_W-1:0],
                        req_tdata[ihrw_pkg::ADDR_W +: ihrw_pkg::DATA_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected transfer: hex_char %h last %b", rsp_tdata, rsp_tlast);
               mismatch_total++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.ch) begin
                  $error("hex_char: expected %h, got %h", want.ch, rsp_tdata);
                  mismatch_total++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  mismatch_total++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      tx_idle_pct = 18;
      rx_idle_pct = 66;

      // First word opens segment zero; extreme data values follow.
      queue_write(ihrw_pkg::FUNC_WORD, 23'h000000, 16'h0000);
      queue_write(ihrw_pkg::FUNC_WORD, 23'h000001, 16'hFFFF);
      queue_write(ihrw_pkg::FUNC_BYTE, 23'h000004, 16'h00A5);
      queue_write(ihrw_pkg::FUNC_BYTE, 23'h000004, 16'hFF5A);
      queue_write(FUNC_UNUSED, 23'h7FFFFF, 16'hFFFF);
      // Top segment takes a linear record; then byte addresses that must not wrap.
      queue_write(ihrw_pkg::FUNC_WORD, 23'h7FFFFF, 16'hFFFF);
      queue_write(ihrw_pkg::FUNC_BYTE, 23'h7FFFFF, 16'h00FF);
      queue_write(ihrw_pkg::FUNC_BYTE, 23'h000000, 16'h0000);
      queue_write(ihrw_pkg::FUNC_CLOSE, 23'h000000, 16'h0000);
      // After close the segment record comes again; fill a line and overflow it.
      for (int i = 0; i < 9; i++) begin
         queue_write(ihrw_pkg::FUNC_WORD, 23'h040000 + 23'(i), 16'h1234 + 16'(i));
      end
      queue_write(ihrw_pkg::FUNC_WORD, 23'h07FFFF, 16'hBEEF);
      queue_write(ihrw_pkg::FUNC_WORD, 23'h080000, 16'hCAFE);
      queue_write(ihrw_pkg::FUNC_CLOSE, 23'h7FFFFF, 16'hFFFF);
      queue_write(ihrw_pkg::FUNC_CLOSE, 23'h000000, 16'h0000);

      queue_random_writes(ITEMS_PER_PASS);
      wait_drained();
      tx_idle_pct = 66;
      rx_idle_pct = 18;
      queue_random_writes(ITEMS_PER_PASS);
      wait_drained();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      queue_random_writes(ITEMS_PER_PASS);
      wait_drained();

      while (expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ihrw_pkg.sv
rtl/core/ihrw_ctrl.sv
rtl/core/ihrw_datapath.sv
rtl/core/intel_hex_record_writer_core.sv
sim/intel_hex_record_writer_core_tb.sv
